/* rtl/hsd_pkg.sv */
// ----------------------------------------------------------------------------
// hsd_pkg
// shared types and constants of the huffman stream decoder
// ----------------------------------------------------------------------------
`default_nettype none

package hsd_pkg;

  // node table depth default, handed down from the top level
  localparam int unsigned NodeSlotsDef = 512;

  // fixed widths of the stream format
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SymW    = 8;
  localparam int unsigned SymCntW = $clog2(SymW);
  localparam int unsigned PadW    = 3;
  localparam int unsigned PosW    = 4;   // bit position 0..8 inside a byte

  // first stream bit of the opening byte sits above the padding count
  localparam logic [PosW-1:0] FirstDataPos = PosW'(PadW);
  localparam logic [PosW-1:0] ByteEndPos   = PosW'(ByteW);

  // depth of the queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  typedef enum logic [1:0] {
    PH_TREE,
    PH_DATA,
    PH_ERROR
  } hsd_phase_e;

  // one classified byte, as queued for the back end
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic [PosW-1:0]  start_pos;
    logic [PosW-1:0]  stop_pos;
  } hsd_beat_t;

endpackage

`default_nettype wire

/* rtl/hsd_front.sv */
// ----------------------------------------------------------------------------
// hsd_front
// accepts input beats and tags each with its usable bit range
// ----------------------------------------------------------------------------
`default_nettype none

module hsd_front import hsd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] in_byte_i,
  input  wire logic             last_byte_i,
  input  wire logic             q_full_i,
  output logic                  q_push_o,
  output hsd_beat_t             q_beat_o
);

  logic            first_q, first_d;
  logic [PadW-1:0] pad_q, pad_d;
  logic [PadW-1:0] pad_sel;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // the opening byte of a stream carries its own padding count
  assign pad_sel = first_q ? in_byte_i[PadW-1:0] : pad_q;

  always_comb begin
    q_beat_o.data      = in_byte_i;
    q_beat_o.last      = last_byte_i;
    q_beat_o.start_pos = first_q ? FirstDataPos : '0;
    q_beat_o.stop_pos  = last_byte_i ? (ByteEndPos - PosW'(pad_sel)) : ByteEndPos;
  end

  always_comb begin
    first_d = first_q;
    pad_d   = pad_q;
    if (q_push_o) begin
      first_d = last_byte_i;
      pad_d   = last_byte_i ? '0 : pad_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      pad_q   <= '0;
    end else begin
      first_q <= first_d;
      pad_q   <= pad_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/hsd_queue.sv */
// ----------------------------------------------------------------------------
// hsd_queue
// short fifo of classified beats between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module hsd_queue import hsd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  hsd_beat_t      push_beat_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           empty_o,
  output hsd_beat_t      head_o
);

  hsd_beat_t         entries_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_beat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/hsd_back.sv */
// ----------------------------------------------------------------------------
// hsd_back
// bit-serial tree builder and code walker with the node table and output
// ----------------------------------------------------------------------------
`default_nettype none

module hsd_back import hsd_pkg::*; #(
  parameter int unsigned NodeSlots = NodeSlotsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_empty_i,
  input  hsd_beat_t            q_head_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [SymW-1:0]      symbol_o,
  output logic                 last_in_run_o,
  output logic                 stream_end_o,
  output logic                 overflow_o
);

  localparam int unsigned IdxW = $clog2(NodeSlots);
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned EntW = 1 + IdxW + SymW;

  // node table: {inner, left child, symbol}
  logic [EntW-1:0] mem [NodeSlots];
  logic [EntW-1:0] rdata_q;
  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  logic [EntW-1:0] mem_wdata;

  hsd_phase_e         phase_q, phase_d;
  logic [CntW-1:0]    cursor_q, cursor_d;
  logic [CntW-1:0]    free_q, free_d;
  logic               leaf_pend_q, leaf_pend_d;
  logic [SymW-1:0]    sym_shift_q, sym_shift_d;
  logic [SymCntW-1:0] sym_cnt_q, sym_cnt_d;
  logic               busy_q, busy_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic               root_inner_q, root_inner_d;
  logic [IdxW-1:0]    root_left_q, root_left_d;
  logic [SymW-1:0]    root_sym_q, root_sym_d;
  logic [IdxW-1:0]    walk_left_q, walk_left_d;
  logic               rd_valid_q, rd_valid_d;

  logic               pend_valid_q, pend_valid_d;
  logic [SymW-1:0]    pend_sym_q, pend_sym_d;
  logic               pend_ovf_q, pend_ovf_d;
  logic               out_valid_q, out_valid_d;
  logic [SymW-1:0]    out_sym_q, out_sym_d;
  logic               out_lir_q, out_lir_d;
  logic               out_se_q, out_se_d;
  logic               out_ovf_q, out_ovf_d;

  logic [PosW-1:0]    cur_pos;
  logic               cur_bit;
  logic               bit_avail;
  logic               rd_inner;
  logic [IdxW-1:0]    rd_left;
  logic [SymW-1:0]    rd_sym;
  logic [IdxW-1:0]    next_base;
  logic [SymW-1:0]    sym_new;
  logic               out_free, room;
  logic               emit, emit_ovf, close;
  logic [SymW-1:0]    emit_sym;

  assign cur_pos   = busy_q ? pos_q : q_head_i.start_pos;
  assign cur_bit   = q_head_i.data[cur_pos[2:0]];
  assign bit_avail = (phase_q != PH_ERROR) && (cur_pos < q_head_i.stop_pos);

  assign rd_inner  = rdata_q[EntW-1];
  assign rd_left   = rdata_q[SymW +: IdxW];
  assign rd_sym    = rdata_q[SymW-1:0];

  // left child of the node the walk stands on
  assign next_base = rd_valid_q ? (rd_inner ? rd_left : root_left_q) : walk_left_q;
  assign sym_new   = sym_shift_q | (SymW'(cur_bit) << sym_cnt_q);

  assign out_free  = !out_valid_q || out_ready_i;
  assign room      = !pend_valid_q || out_free;

  // bit engine
  always_comb begin
    phase_d      = phase_q;
    cursor_d     = cursor_q;
    free_d       = free_q;
    leaf_pend_d  = leaf_pend_q;
    sym_shift_d  = sym_shift_q;
    sym_cnt_d    = sym_cnt_q;
    busy_d       = busy_q;
    pos_d        = pos_q;
    root_inner_d = root_inner_q;
    root_left_d  = root_left_q;
    root_sym_d   = root_sym_q;
    walk_left_d  = walk_left_q;
    rd_valid_d   = rd_valid_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = cursor_q[IdxW-1:0];
    mem_wdata    = '0;
    mem_raddr    = next_base + IdxW'(!cur_bit);
    emit         = 1'b0;
    emit_ovf     = 1'b0;
    emit_sym     = '0;
    close        = 1'b0;
    q_pop_o      = 1'b0;

    if (!q_empty_i) begin
      if (bit_avail) begin
        case (phase_q)
          PH_TREE: begin
            if (leaf_pend_q) begin
              busy_d = 1'b1;
              pos_d  = cur_pos + 1'b1;
              sym_shift_d = sym_new;
              if (sym_cnt_q == SymCntW'(SymW-1)) begin
                mem_we    = 1'b1;
                mem_wdata = {1'b0, {IdxW{1'b0}}, sym_new};
                if (cursor_q == '0) begin
                  root_inner_d = 1'b0;
                  root_sym_d   = sym_new;
                end
                leaf_pend_d = 1'b0;
                sym_cnt_d   = '0;
                cursor_d    = cursor_q + 1'b1;
                if ((cursor_q + 1'b1) >= free_q) begin
                  phase_d     = PH_DATA;
                  walk_left_d = root_left_q;
                  rd_valid_d  = 1'b0;
                end
              end else begin
                sym_cnt_d = sym_cnt_q + 1'b1;
              end
            end else if (cur_bit) begin
              if (({1'b0, free_q} + (CntW+1)'(2)) > (CntW+1)'(NodeSlots)) begin
                // table full: report once, skip the rest of the stream
                if (room) begin
                  emit     = 1'b1;
                  emit_ovf = 1'b1;
                  phase_d  = PH_ERROR;
                end
              end else begin
                busy_d    = 1'b1;
                pos_d     = cur_pos + 1'b1;
                mem_we    = 1'b1;
                mem_wdata = {1'b1, free_q[IdxW-1:0], {SymW{1'b0}}};
                if (cursor_q == '0) begin
                  root_inner_d = 1'b1;
                  root_left_d  = free_q[IdxW-1:0];
                end
                free_d   = free_q + CntW'(2);
                cursor_d = cursor_q + 1'b1;
              end
            end else begin
              busy_d      = 1'b1;
              pos_d       = cur_pos + 1'b1;
              leaf_pend_d = 1'b1;
              sym_shift_d = '0;
              sym_cnt_d   = '0;
            end
          end
          PH_DATA: begin
            if (!root_inner_q) begin
              // single leaf tree
              if (room) begin
                emit     = 1'b1;
                emit_sym = root_sym_q;
                busy_d   = 1'b1;
                pos_d    = cur_pos + 1'b1;
              end
            end else if (rd_valid_q && !rd_inner) begin
              if (room) begin
                emit       = 1'b1;
                emit_sym   = rd_sym;
                mem_re     = 1'b1;
                rd_valid_d = 1'b1;
                busy_d     = 1'b1;
                pos_d      = cur_pos + 1'b1;
              end
            end else begin
              mem_re     = 1'b1;
              rd_valid_d = 1'b1;
              busy_d     = 1'b1;
              pos_d      = cur_pos + 1'b1;
            end
          end
          default: ;
        endcase
      end else if (rd_valid_q) begin
        // settle the read still in flight before the byte is closed
        if (!rd_inner) begin
          if (room) begin
            emit        = 1'b1;
            emit_sym    = rd_sym;
            walk_left_d = next_base;
            rd_valid_d  = 1'b0;
          end
        end else begin
          walk_left_d = next_base;
          rd_valid_d  = 1'b0;
        end
      end else if (room) begin
        close   = 1'b1;
        q_pop_o = 1'b1;
        busy_d  = 1'b0;
        if (q_head_i.last) begin
          phase_d     = PH_TREE;
          cursor_d    = '0;
          free_d      = CntW'(1);
          leaf_pend_d = 1'b0;
          sym_shift_d = '0;
          sym_cnt_d   = '0;
          rd_valid_d  = 1'b0;
        end
      end
    end
  end

  // pending result and output register
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    pend_ovf_d   = pend_ovf_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_sym_d    = out_sym_q;
    out_lir_d    = out_lir_q;
    out_se_d     = out_se_q;
    out_ovf_d    = out_ovf_q;
    if (emit) begin
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_sym_d   = pend_sym_q;
        out_lir_d   = 1'b0;
        out_se_d    = 1'b0;
        out_ovf_d   = pend_ovf_q;
      end
      pend_valid_d = 1'b1;
      pend_sym_d   = emit_sym;
      pend_ovf_d   = emit_ovf;
    end else if (close && pend_valid_q) begin
      out_valid_d  = 1'b1;
      out_sym_d    = pend_sym_q;
      out_lir_d    = 1'b1;
      out_se_d     = q_head_i.last;
      out_ovf_d    = pend_ovf_q;
      pend_valid_d = 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign symbol_o      = out_sym_q;
  assign last_in_run_o = out_lir_q;
  assign stream_end_o  = out_se_q;
  assign overflow_o    = out_ovf_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    sym_shift_q <= sym_shift_d;
    root_left_q <= root_left_d;
    root_sym_q  <= root_sym_d;
    walk_left_q <= walk_left_d;
    pos_q       <= pos_d;
    pend_sym_q  <= pend_sym_d;
    pend_ovf_q  <= pend_ovf_d;
    out_sym_q   <= out_sym_d;
    out_lir_q   <= out_lir_d;
    out_se_q    <= out_se_d;
    out_ovf_q   <= out_ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_TREE;
      cursor_q     <= '0;
      free_q       <= CntW'(1);
      leaf_pend_q  <= 1'b0;
      sym_cnt_q    <= '0;
      busy_q       <= 1'b0;
      root_inner_q <= 1'b0;
      rd_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      cursor_q     <= cursor_d;
      free_q       <= free_d;
      leaf_pend_q  <= leaf_pend_d;
      sym_cnt_q    <= sym_cnt_d;
      busy_q       <= busy_d;
      root_inner_q <= root_inner_d;
      rd_valid_q   <= rd_valid_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/huffman_stream_decoder.sv */
// ----------------------------------------------------------------------------
// huffman_stream_decoder
// lsb-first huffman decoder with in-band breadth-first tree description
// ----------------------------------------------------------------------------
// Compressed bytes enter one beat at a time with a last-byte flag and leave as
// decoded symbol beats. The opening byte of a stream carries the padding count
// in its low three bits; the tree description follows, then the code words.
// Usable bits are taken one at a time, both while the tree is written and
// while code words are walked, and every walk step is one dependent read of
// the node table. A byte is closed in a step of its own, after a further
// step when a node-table read is still in flight at the end of the byte.
// Up to two bytes wait in the input queue, and one finished symbol beat
// waits in the output register while decoding goes on. An overflow of the
// node table gives one beat with overflow set; the stream is then skipped
// until its last byte. There is no clearing pass: the node table is only
// read where it was written.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_stream_decoder import hsd_pkg::*; #(
  parameter int unsigned NODE_SLOTS = NodeSlotsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // compressed byte channel
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] in_byte_i,
  input  wire logic             last_byte_i,
  // decoded symbol channel
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [SymW-1:0]       symbol_o,
  output logic                  last_in_run_o,
  output logic                  stream_end_o,
  output logic                  overflow_o
);

  // queue between the front classifier and the back decoder
  logic      q_push, q_full, q_pop, q_empty;
  hsd_beat_t q_push_beat, q_head;

  // front: accept beats, work out the usable bit range of each byte
  hsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_beat_o    (q_push_beat)
  );

  hsd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_beat_i (q_push_beat),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  // back: tree build, code walk, symbol output
  hsd_back #(
    .NodeSlots (NODE_SLOTS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .symbol_o      (symbol_o),
    .last_in_run_o (last_in_run_o),
    .stream_end_o  (stream_end_o),
    .overflow_o    (overflow_o)
  );

endmodule

`default_nettype wire
